### rtl/mfrd_pkg.sv
`default_nettype none
package mfrd_pkg;

  localparam int ROW_BYTES   = 50;
  localparam int ROWS        = 300;
  localparam int FRAME_BYTES = 15000;
  localparam int PANEL_W     = ROW_BYTES * 8;
  localparam int QDEPTH      = 2;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_PIXEL = 3'd2;
  localparam logic [2:0] CMD_LINE  = 3'd3;
  localparam logic [2:0] CMD_RECT  = 3'd4;

  typedef enum logic [1:0] {
    K_NOP,
    K_WRITE,
    K_READ,
    K_DRAW
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDATA,
    S_FETCH,
    S_MOD
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [8:0]  x0;
    logic [8:0]  x1;
    logic [8:0]  y0;
    logic [8:0]  y1;
    logic [5:0]  cs;
    logic [5:0]  ce;
    logic        color;
    logic        fill_en;
    logic        fill_on;
    logic [13:0] addr;
    logic [7:0]  data;
    logic [13:0] base;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/mfrd_front.sv
`default_nettype none
module mfrd_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push,
  output logic              full,
  input  wire  [2:0]        command_i,
  input  wire  [8:0]        ax_i,
  input  wire  [8:0]        ay_i,
  input  wire  [8:0]        bx_i,
  input  wire  [8:0]        by_i,
  input  wire               color_i,
  input  wire signed [1:0]  fill_mode_i,
  input  wire  [13:0]       byte_addr_i,
  input  wire  [7:0]        byte_data_i,
  output logic              cmd_valid_o,
  output mfrd_pkg::cmd_t    cmd_o,
  input  wire               cmd_pop_i
);
  import mfrd_pkg::*;

  cmd_t       q_mem [QDEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cmd_t       c;
  logic [8:0] xe;
  logic       do_push, do_pop;

  always_comb begin
    c = '0;
    c.addr  = byte_addr_i;
    c.data  = byte_data_i;
    c.color = color_i;
    c.x0 = (ax_i <= bx_i) ? ax_i : bx_i;
    c.x1 = (ax_i <= bx_i) ? bx_i : ax_i;
    c.y0 = (ay_i <= by_i) ? ay_i : by_i;
    c.y1 = (ay_i <= by_i) ? by_i : ay_i;
    c.kind = K_NOP;
    case (command_i)
      CMD_WRITE: if (byte_addr_i < 14'(FRAME_BYTES)) c.kind = K_WRITE;
      CMD_READ:  if (byte_addr_i < 14'(FRAME_BYTES)) c.kind = K_READ;
      CMD_PIXEL: begin
        c.kind = K_DRAW;
        c.x0 = ax_i;
        c.x1 = ax_i;
        c.y0 = ay_i;
        c.y1 = ay_i;
      end
      CMD_LINE:  if (ax_i == bx_i || ay_i == by_i) c.kind = K_DRAW;
      CMD_RECT: begin
        c.kind    = K_DRAW;
        c.fill_en = (fill_mode_i != 2'sd0) && ((c.x1 - c.x0) >= 9'd2);
        c.fill_on = (fill_mode_i == 2'sd1);
      end
      default: c.kind = K_NOP;
    endcase
    xe   = (c.x1 < 9'(PANEL_W)) ? c.x1 : 9'(PANEL_W - 1);
    c.cs = c.x0[8:3];
    c.ce = xe[8:3];
    c.base = 14'(c.y0) * 14'(ROW_BYTES);
  end

  assign full        = (cnt_q == 2'(QDEPTH));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wptr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

### rtl/mfrd_back.sv
`default_nettype none
module mfrd_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            cmd_valid_i,
  input  mfrd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  wire            res_full_i,
  output logic           res_push_o,
  output logic [7:0]     res_data_o
);
  import mfrd_pkg::*;

  logic [7:0]  mem [FRAME_BYTES];
  logic [7:0]  mem_q;
  logic        mem_we, mem_re;
  logic [13:0] mem_addr;
  logic [7:0]  mem_wd;

  state_e      state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [8:0]  y_q, y_d;
  logic [5:0]  col_q, col_d;
  logic [13:0] rowbase_q, rowbase_d;
  logic [7:0]  setm, clrm;

  always_comb begin
    logic [8:0] x;
    logic       edge_row, inr, val, hit;
    setm = '0;
    clrm = '0;
    edge_row = (y_q == cur_q.y0) || (y_q == cur_q.y1);
    for (int i = 0; i < 8; i++) begin
      x   = {col_q, 3'(i)};
      inr = (x >= cur_q.x0) && (x <= cur_q.x1) && (x < 9'(PANEL_W));
      hit = 1'b0;
      val = 1'b0;
      if (inr) begin
        if (edge_row || x == cur_q.x0 || x == cur_q.x1) begin
          hit = 1'b1;
          val = cur_q.color;
        end else if (cur_q.fill_en) begin
          hit = 1'b1;
          val = cur_q.fill_on;
        end
      end
      setm[7 - i] = hit && val;
      clrm[7 - i] = hit && !val;
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    y_d        = y_q;
    col_d      = col_q;
    rowbase_d  = rowbase_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_data_o = 8'd0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = cmd_i.addr;
    mem_wd     = cmd_i.data;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            K_WRITE: begin
              mem_we     = 1'b1;
              res_push_o = 1'b1;
            end
            K_READ: begin
              mem_re  = 1'b1;
              state_d = S_RDATA;
            end
            K_DRAW: begin
              cur_d     = cmd_i;
              y_d       = cmd_i.y0;
              col_d     = cmd_i.cs;
              rowbase_d = cmd_i.base;
              if (cmd_i.y0 >= 9'(ROWS) || cmd_i.x0 >= 9'(PANEL_W)) begin
                res_push_o = 1'b1;
              end else begin
                state_d = S_FETCH;
              end
            end
            default: res_push_o = 1'b1;
          endcase
        end
      end
      S_RDATA: begin
        res_push_o = 1'b1;
        res_data_o = mem_q;
        state_d    = S_IDLE;
      end
      S_FETCH: begin
        mem_addr = rowbase_q + 14'(col_q);
        mem_re   = 1'b1;
        state_d  = S_MOD;
      end
      S_MOD: begin
        mem_addr = rowbase_q + 14'(col_q);
        mem_wd   = (mem_q | setm) & ~clrm;
        mem_we   = |(setm | clrm);
        state_d  = S_FETCH;
        if (col_q == cur_q.ce) begin
          if (y_q == cur_q.y1 || y_q == 9'(ROWS - 1)) begin
            res_push_o = 1'b1;
            state_d    = S_IDLE;
          end else begin
            y_d       = y_q + 9'd1;
            rowbase_d = rowbase_q + 14'(ROW_BYTES);
            col_d     = cur_q.cs;
          end
        end else begin
          col_d = col_q + 6'd1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    y_q       <= y_d;
    col_q     <= col_d;
    rowbase_q <= rowbase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_mod_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD |-> $past(state_q) == S_FETCH)
    else $error("modify without fetch");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == S_IDLE && cmd_valid_i)
    else $error("item taken while busy");

endmodule
`default_nettype wire

### rtl/mfrd_res_fifo.sv
`default_nettype none
module mfrd_res_fifo (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  wire  [7:0] data_i,
  output logic       full_o,
  output logic       empty_o,
  input  wire        pop_i,
  output logic [7:0] data_o
);
  import mfrd_pkg::*;

  logic [7:0] q_mem [QDEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'(QDEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = q_mem[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

### rtl/mono_framebuffer_rect_draw.sv
// write and no-op items: command queue, then sequencer, then result queue; a read adds S_RDATA
// write/no-op: one item per cycle while the result queue has space; a read holds the sequencer in S_RDATA
// drawing: each byte covered is read in S_FETCH, then modified and written in S_MOD; rows clipped
// reset clears queues and the sequencer; framebuffer contents are undefined until written
`default_nettype none
module mono_framebuffer_rect_draw (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push,
  output logic             full,
  input  wire  [2:0]       command_i,
  input  wire  [8:0]       ax_i,
  input  wire  [8:0]       ay_i,
  input  wire  [8:0]       bx_i,
  input  wire  [8:0]       by_i,
  input  wire              color_i,
  input  wire signed [1:0] fill_mode_i,
  input  wire  [13:0]      byte_addr_i,
  input  wire  [7:0]       byte_data_i,
  output logic             empty,
  input  wire              pop,
  output logic [7:0]       read_data_o
);
  import mfrd_pkg::*;

  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;
  logic       res_full, res_push;
  logic [7:0] res_data;

  mfrd_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .command_i, .ax_i, .ay_i, .bx_i, .by_i, .color_i, .fill_mode_i,
    .byte_addr_i, .byte_data_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mfrd_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_data_o  (res_data)
  );

  mfrd_res_fifo u_res (
    .clk_i, .rst_ni,
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (read_data_o)
  );

endmodule
`default_nettype wire
